// ----- rtl/ott_pkg.sv -----
// Package for the ordered timer table: sizes, command codes and channel payload types.
// Used by the top level and the testbench; depends on nothing.
`default_nettype none
package ott_pkg;
    localparam int NumSlotsDefault = 16;
    localparam int RolloverMsDefault = 3600000;

    typedef enum logic [2:0] {
        CMD_ADD = 3'd0, CMD_CANCEL = 3'd1, CMD_REFRESH = 3'd2,
        CMD_RESET = 3'd3, CMD_EXPIRE = 3'd4, CMD_NEXT = 3'd5
    } t_cmd;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [3:0]  timer_id;
        logic [31:0] period_ms;
        logic        repeat_flag;
        logic        restart_now;
        logic [63:0] now_ms;
    } t_in;

    typedef struct packed {
        logic [3:0]  slot_id;
        logic        ok;
        logic        expired_valid;
        logic [63:0] time_to_next;
        logic        front_notify;
        logic        rollover_seen;
        logic        last;
    } t_out;
endpackage
`default_nettype wire

// ----- rtl/ott_if.sv -----
// Valid/ready channel interface carrying one item of type T.
// Depends on nothing.
`default_nettype none
interface ott_if #(parameter type T = logic) (input wire logic i_clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/ott_ram.sv -----
// Generic single-port RAM with registered read.
// Depends on nothing.
`default_nettype none
module ott_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_addr,
    input  wire logic [Width-1:0]         i_wdata,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    // Registered read; a read of the address being written returns the old data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// ----- rtl/ordered_timer_table.sv -----
// Top level of the ordered timer table: sequencer, slot RAMs and output register.
// Depends on ott_pkg, ott_if and ott_ram.
//
//  channel | dir | payload
//  in_ch   | in  | cmd, timer_id, period_ms, repeat_flag, restart_now, now_ms
//  out_ch  | out | slot_id, ok, expired_valid, time_to_next, front_notify,
//          |     | rollover_seen, last
//
// Each item starts with one scan of the slots, a read step and a compare step per
// slot through the single RAM port; a plain result is formed after that scan.
// An add or reset that stores a slot scans once more for the front notice.
// Expire scans again after each expired slot.
// Reset clears valid bits, recurring bits, previous time and tickled at once.
// A result waits in the output register; the sequencer stalls until it is taken.
`default_nettype none
module ordered_timer_table
    import ott_pkg::*;
#(
    parameter int NUM_SLOTS = NumSlotsDefault,
    parameter int ROLLOVER_MS = RolloverMsDefault
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    ott_if.sink      in_ch,
    ott_if.source    out_ch
);
    localparam int U  = (NUM_SLOTS < 16) ? NUM_SLOTS : 16;
    localparam int AW = $clog2(U);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN_A, S_SCAN_D, S_DONE, S_WR_A, S_WR_D, S_SEND, S_EXP_A,
        S_EXP_D, S_EXP_WR, S_FRONT_A, S_FRONT_D
    } t_state;

    t_state      r_state;
    t_in         r_in;
    t_out        r_out;
    logic        r_ovalid;
    logic [U-1:0] r_valid, r_rec, r_taken;
    logic [63:0] r_prev;
    logic        r_tickled;
    logic [4:0]  r_idx;
    logic        r_phase;
    logic        r_best_ok;
    logic [3:0]  r_best;
    logic [63:0] r_best_exp;
    logic [31:0] r_per;
    logic [63:0] r_exp;
    logic        r_ro;
    logic        r_any;
    logic [3:0]  r_tgt;

    // Slot RAMs share one address.
    logic        per_we, exp_we;
    logic [AW-1:0] ram_addr;
    logic [31:0] per_wd, per_rd;
    logic [63:0] exp_wd, exp_rd;

    ott_ram #(.Width(32), .Depth(1 << AW)) u_per (
        .i_clk(i_clk), .i_we(per_we), .i_addr(ram_addr),
        .i_wdata(per_wd), .o_rdata(per_rd));
    ott_ram #(.Width(64), .Depth(1 << AW)) u_exp (
        .i_clk(i_clk), .i_we(exp_we), .i_addr(ram_addr),
        .i_wdata(exp_wd), .o_rdata(exp_rd));

    logic [4:0] free_idx;
    logic       free_ok;
    logic       in_rng;
    logic [3:0] cur;
    logic       cand;
    logic       better;
    logic [63:0] now;

    assign now    = r_in.now_ms;
    assign in_rng = ({1'b0, r_in.timer_id} < 5'(U));
    assign cur    = r_idx[3:0];

    // First free slot, a priority encode over the valid bits.
    always_comb begin
        free_idx = '0;
        free_ok  = 1'b0;
        for (int i = U - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_idx = 5'(i);
                free_ok  = 1'b1;
            end
        end
    end

    // Shared compare: is the slot just read a better candidate?
    always_comb begin
        cand = r_valid[cur[AW-1:0]];
        if (r_state == S_EXP_D) begin
            cand = cand && !r_taken[cur[AW-1:0]] && (r_ro || !(exp_rd > now));
        end
        better = cand && (!r_best_ok || (exp_rd < r_best_exp));
    end

    // RAM address and write data.
    always_comb begin
        ram_addr = cur[AW-1:0];
        per_we = 1'b0;
        exp_we = 1'b0;
        per_wd = r_per;
        exp_wd = r_exp;
        if (r_state == S_WR_A || r_state == S_WR_D || r_state == S_EXP_WR
            || r_state == S_DONE) begin
            ram_addr = r_tgt[AW-1:0];
        end
        if (r_state == S_WR_D) begin
            per_we = 1'b1;
            exp_we = 1'b1;
        end
        // The period of the expired slot is on the read port in the second phase.
        if (r_state == S_EXP_WR && r_phase) begin
            exp_we = 1'b1;
            exp_wd = now + {32'd0, per_rd};
        end
    end

    assign in_ch.ready  = (r_state == S_IDLE) && !r_ovalid;
    assign out_ch.valid = r_ovalid;
    assign out_ch.data  = r_out;

    // Sequencer with registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ovalid  <= 1'b0;
            r_valid   <= '0;
            r_rec     <= '0;
            r_prev    <= '0;
            r_tickled <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_ch.valid && in_ch.ready) begin
                        r_in      <= in_ch.data;
                        r_out     <= '0;
                        r_idx     <= '0;
                        r_best_ok <= 1'b0;
                        r_taken   <= '0;
                        r_tgt     <= in_ch.data.timer_id;
                        r_state   <= S_SCAN_A;
                    end
                end
                // Earliest-slot scan over all slots, one RAM read per step.
                S_SCAN_A: begin
                    r_state <= S_SCAN_D;
                end
                S_SCAN_D: begin
                    if (better) begin
                        r_best_ok  <= 1'b1;
                        r_best     <= cur;
                        r_best_exp <= exp_rd;
                    end
                    if (r_idx == 5'(U - 1)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_idx   <= r_idx + 5'd1;
                        r_state <= S_SCAN_A;
                    end
                end
                // Reads the addressed slot (at r_tgt) and decides the command.
                S_DONE: begin
                    r_state <= S_WR_A;
                end
                S_WR_A: begin
                    r_out.last <= 1'b1;
                    unique case (r_in.cmd)
                        CMD_ADD: begin
                            if (free_ok) begin
                                r_tgt <= free_idx[3:0];
                                r_per <= {16'd0, r_in.period_ms[15:0]};
                                r_exp <= now + {48'd0, r_in.period_ms[15:0]};
                                r_valid[free_idx[AW-1:0]] <= 1'b1;
                                r_rec[free_idx[AW-1:0]] <= r_in.repeat_flag;
                                r_out.slot_id <= free_idx[3:0];
                                r_out.ok <= 1'b1;
                                r_state <= S_WR_D;
                            end else begin
                                r_state <= S_SEND;
                            end
                        end
                        CMD_CANCEL, CMD_REFRESH: begin
                            r_out.slot_id <= r_in.timer_id;
                            if (in_rng && r_valid[r_in.timer_id[AW-1:0]]) begin
                                r_out.ok <= 1'b1;
                                if (r_in.cmd == CMD_CANCEL) begin
                                    r_valid[r_in.timer_id[AW-1:0]] <= 1'b0;
                                    r_state <= S_SEND;
                                end else begin
                                    r_per <= per_rd;
                                    r_exp <= now + {32'd0, per_rd};
                                    r_state <= S_WR_D;
                                end
                            end else begin
                                r_state <= S_SEND;
                            end
                        end
                        CMD_RESET: begin
                            r_out.slot_id <= r_in.timer_id;
                            if (!in_rng) begin
                                r_out.ok <= 1'b0;
                                r_state <= S_SEND;
                            end else if (r_in.period_ms == per_rd
                                         && !r_in.restart_now) begin
                                r_out.ok <= 1'b1;
                                r_state <= S_SEND;
                            end else if (r_valid[r_in.timer_id[AW-1:0]]) begin
                                r_out.ok <= 1'b1;
                                r_per <= r_in.period_ms;
                                r_exp <= (r_in.restart_now ? now
                                          : exp_rd - {32'd0, per_rd})
                                         + {32'd0, r_in.period_ms};
                                r_state <= S_WR_D;
                            end else begin
                                r_state <= S_SEND;
                            end
                        end
                        CMD_EXPIRE: begin
                            r_out.ok <= 1'b1;
                            if (r_best_ok) begin
                                r_prev <= now;
                                r_ro <= (now < r_prev)
                                        && ((r_prev - now) > 64'(ROLLOVER_MS));
                                if (((now < r_prev)
                                     && ((r_prev - now) > 64'(ROLLOVER_MS)))
                                    || !(r_best_exp > now)) begin
                                    r_idx <= '0;
                                    r_best_ok <= 1'b0;
                                    r_any <= 1'b0;
                                    r_state <= S_EXP_A;
                                end else begin
                                    r_state <= S_SEND;
                                end
                            end else begin
                                r_state <= S_SEND;
                            end
                        end
                        CMD_NEXT: begin
                            r_out.ok <= 1'b1;
                            r_tickled <= 1'b0;
                            if (!r_best_ok) begin
                                r_out.time_to_next <= '1;
                            end else if (now >= r_best_exp) begin
                                r_out.time_to_next <= '0;
                            end else begin
                                r_out.time_to_next <= r_best_exp - now;
                            end
                            r_state <= S_SEND;
                        end
                        default: begin
                            r_state <= S_SEND;
                        end
                    endcase
                end
                // Store the slot; add and reset then rescan for the front notice.
                S_WR_D: begin
                    r_idx     <= '0;
                    r_best_ok <= 1'b0;
                    r_state   <= (r_in.cmd == CMD_REFRESH) ? S_SEND : S_FRONT_A;
                end
                S_FRONT_A: begin
                    r_state <= S_FRONT_D;
                end
                S_FRONT_D: begin
                    if (better) begin
                        r_best_ok  <= 1'b1;
                        r_best     <= cur;
                        r_best_exp <= exp_rd;
                    end
                    if (r_idx == 5'(U - 1)) begin
                        if ((better ? cur : r_best) == r_tgt && !r_tickled) begin
                            r_tickled <= 1'b1;
                            r_out.front_notify <= 1'b1;
                        end
                        r_state <= S_SEND;
                    end else begin
                        r_idx   <= r_idx + 5'd1;
                        r_state <= S_FRONT_A;
                    end
                end
                // Expire: one scan per due slot picks the next in order. The
                // pending result goes out once the scan shows whether it is last.
                S_EXP_A: begin
                    r_state <= S_EXP_D;
                end
                S_EXP_D: begin
                    if (better) begin
                        r_best_ok  <= 1'b1;
                        r_best     <= cur;
                        r_best_exp <= exp_rd;
                    end
                    if (r_idx == 5'(U - 1)) begin
                        r_tgt   <= better ? cur : r_best;
                        r_phase <= 1'b0;
                        if (better || r_best_ok) begin
                            if (r_any) begin
                                r_ovalid <= 1'b1;
                            end
                            r_state <= S_EXP_WR;
                        end else begin
                            r_out.last <= 1'b1;
                            r_state <= S_SEND;
                        end
                    end else begin
                        r_idx   <= r_idx + 5'd1;
                        r_state <= S_EXP_A;
                    end
                end
                S_EXP_WR: begin
                    if (!r_phase) begin
                        // Read period of the target, then rearm or free.
                        r_phase <= 1'b1;
                        r_any   <= 1'b1;
                        r_taken[r_tgt[AW-1:0]] <= 1'b1;
                        if (!r_rec[r_tgt[AW-1:0]]) begin
                            r_valid[r_tgt[AW-1:0]] <= 1'b0;
                        end
                    end else if (!r_ovalid) begin
                        r_out.slot_id <= r_tgt;
                        r_out.ok <= 1'b1;
                        r_out.expired_valid <= 1'b1;
                        r_out.rollover_seen <= r_ro;
                        r_out.last <= 1'b0;
                        r_idx <= '0;
                        r_best_ok <= 1'b0;
                        r_state <= S_EXP_A;
                    end
                end
                S_SEND: begin
                    if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Input is refused while an item is in progress.
    property p_no_accept_busy;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !in_ch.ready;
    endproperty
    a_no_accept_busy: assert property (p_no_accept_busy)
        else $error("input accepted while busy");

    property p_hold;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !out_ch.ready) |=> (r_ovalid && $stable(r_out));
    endproperty
    a_hold: assert property (p_hold) else $error("stalled result changed");

    property p_expire_ok;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_out.expired_valid) |-> r_out.ok;
    endproperty
    a_expire_ok: assert property (p_expire_ok) else $error("expired without ok");
endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the ordered timer table.
// Drives timer commands, predicts each result in a local slot model and compares.
// Depends on ott_pkg, ott_if and the ordered_timer_table RTL.
module testbench;
    import ott_pkg::*;

    localparam int SLOTS = 16;
    localparam longint unsigned ROLLOVER = 64'd3600000;
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_AT = 200;
    localparam int HOLD_LEN = 400;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ott_if #(.T(t_in)) in_ch (i_clk);
    ott_if #(.T(t_out)) out_ch (i_clk);

    ordered_timer_table dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
    );

    // Clock generation.
    always begin
        #4 i_clk = ~i_clk;
    end

    // Local copy of the timer table.
    bit              tm_valid [SLOTS];
    bit              tm_recur [SLOTS];
    bit [31:0]       tm_period [SLOTS];
    longint unsigned tm_expiry [SLOTS];
    bit              tm_written [SLOTS];
    longint unsigned tm_prev;
    bit              tm_tickled;

    t_in  pending_cmds[$];
    t_out expected_results[$];
    int   errors = 0;
    longint unsigned clock_ms = 64'd1000;

    function automatic void add_expected(t_out r);
        expected_results.insert(expected_results.size(), r);
    endfunction

    function automatic bit earlier(int a, int b);
        if (tm_expiry[a] != tm_expiry[b]) return tm_expiry[a] < tm_expiry[b];
        return a < b;
    endfunction

    function automatic int first_slot();
        int best;
        best = -1;
        for (int i = 0; i < SLOTS; i++)
            if (tm_valid[i] && (best < 0 || earlier(i, best))) best = i;
        return best;
    endfunction

    function automatic bit notify_front(int s);
        if (first_slot() == s && !tm_tickled) begin
            tm_tickled = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_out blank_result(logic [3:0] sid, logic ok);
        t_out r;
        r = '0;
        r.slot_id = sid;
        r.ok = ok;
        r.last = 1'b1;
        return r;
    endfunction

    // Predict every result of one accepted command and queue it.
    function automatic void predict_timer(t_in c);
        t_out r;
        int f, s, e, n, best;
        bit ro;
        bit taken [SLOTS];
        int order [SLOTS];
        longint unsigned start;
        s = c.timer_id;
        case (c.cmd)
            CMD_ADD: begin
                f = -1;
                for (int i = 0; i < SLOTS; i++)
                    if (!tm_valid[i] && f < 0) f = i;
                if (f < 0) begin
                    add_expected(blank_result(4'd0, 1'b0));
                end else begin
                    tm_valid[f] = 1'b1;
                    tm_written[f] = 1'b1;
                    tm_recur[f] = c.repeat_flag;
                    tm_period[f] = {16'd0, c.period_ms[15:0]};
                    tm_expiry[f] = c.now_ms + tm_period[f];
                    r = blank_result(4'(f), 1'b1);
                    r.front_notify = notify_front(f);
                    add_expected(r);
                end
            end
            CMD_CANCEL, CMD_REFRESH: begin
                if (!tm_valid[s]) begin
                    add_expected(blank_result(c.timer_id, 1'b0));
                end else begin
                    if (c.cmd == CMD_CANCEL) tm_valid[s] = 1'b0;
                    else tm_expiry[s] = c.now_ms + tm_period[s];
                    add_expected(blank_result(c.timer_id, 1'b1));
                end
            end
            CMD_RESET: begin
                if (c.period_ms == tm_period[s] && !c.restart_now) begin
                    add_expected(blank_result(c.timer_id, 1'b1));
                end else if (!tm_valid[s]) begin
                    add_expected(blank_result(c.timer_id, 1'b0));
                end else begin
                    start = c.restart_now ? c.now_ms : tm_expiry[s] - tm_period[s];
                    tm_period[s] = c.period_ms;
                    tm_expiry[s] = start + c.period_ms;
                    r = blank_result(c.timer_id, 1'b1);
                    r.front_notify = notify_front(s);
                    add_expected(r);
                end
            end
            CMD_EXPIRE: begin
                e = first_slot();
                if (e < 0) begin
                    add_expected(blank_result(4'd0, 1'b1));
                end else begin
                    ro = c.now_ms < tm_prev && (tm_prev - c.now_ms) > ROLLOVER;
                    tm_prev = c.now_ms;
                    if (!ro && tm_expiry[e] > c.now_ms) begin
                        add_expected(blank_result(4'd0, 1'b1));
                    end else begin
                        n = 0;
                        foreach (taken[i]) taken[i] = 1'b0;
                        do begin
                            best = -1;
                            for (int i = 0; i < SLOTS; i++) begin
                                if (tm_valid[i] && !taken[i] &&
                                    (ro || tm_expiry[i] <= c.now_ms) &&
                                    (best < 0 || earlier(i, best)))
                                    best = i;
                            end
                            if (best >= 0) begin
                                taken[best] = 1'b1;
                                order[n] = best;
                                n++;
                            end
                        end while (best >= 0);
                        for (int k = 0; k < n; k++) begin
                            if (tm_recur[order[k]])
                                tm_expiry[order[k]] = c.now_ms + tm_period[order[k]];
                            else
                                tm_valid[order[k]] = 1'b0;
                            r = blank_result(4'(order[k]), 1'b1);
                            r.expired_valid = 1'b1;
                            r.rollover_seen = ro;
                            r.last = (k == n - 1);
                            add_expected(r);
                        end
                    end
                end
            end
            CMD_NEXT: begin
                e = first_slot();
                tm_tickled = 1'b0;
                r = blank_result(4'd0, 1'b1);
                if (e < 0) r.time_to_next = '1;
                else if (c.now_ms >= tm_expiry[e]) r.time_to_next = '0;
                else r.time_to_next = tm_expiry[e] - c.now_ms;
                add_expected(r);
            end
            default: add_expected(blank_result(4'd0, 1'b0));
        endcase
    endfunction

    // Build one command from its fields.
    function automatic t_in make_cmd(logic [2:0] op, logic [3:0] id, logic [31:0] per,
                                     logic rep, logic rn, longint unsigned now);
        t_in c;
        c.cmd = op;
        c.timer_id = id;
        c.period_ms = per;
        c.repeat_flag = rep;
        c.restart_now = rn;
        c.now_ms = now;
        return c;
    endfunction

    function automatic logic [31:0] rand_period();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom();
            default: return $urandom_range(1, 3000);
        endcase
    endfunction

    // Random command mix. A reset from the old start is only sent to a slot whose
    // period has already been stored, since an unstored period has no defined value.
    function automatic t_in random_cmd();
        logic [2:0] op;
        logic [3:0] id;
        logic [31:0] per;
        logic rn;
        int pick;
        pick = $urandom_range(0, 99);
        case (1'b1)
            pick < 25: op = CMD_ADD;
            pick < 35: op = CMD_CANCEL;
            pick < 45: op = CMD_REFRESH;
            pick < 60: op = CMD_RESET;
            pick < 85: op = CMD_EXPIRE;
            pick < 97: op = CMD_NEXT;
            default:   op = 3'($urandom_range(6, 7));
        endcase
        case ($urandom_range(0, 9))
            0: clock_ms = clock_ms - $urandom_range(3600001, 9000000);
            1: clock_ms = {$urandom(), $urandom()};
            default: clock_ms = clock_ms + $urandom_range(0, 1500);
        endcase
        id = 4'($urandom_range(0, 15));
        per = rand_period();
        rn = 1'($urandom_range(0, 1));
        if (op == CMD_RESET && !rn && !tm_written[id]) rn = 1'b1;
        return make_cmd(op, id, per, 1'($urandom_range(0, 1)), rn, clock_ms);
    endfunction

    // Driver: predicts each accepted item and idles for a random gap
    // after it.
    int drv_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            drv_gap <= 0;
        end else begin
            if (in_ch.valid && in_ch.ready) predict_timer(in_ch.data);
            if (in_ch.valid && !in_ch.ready) begin
                // Hold the current item.
            end else if (drv_gap > 0) begin
                drv_gap <= drv_gap - 1;
                in_ch.valid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                in_ch.data <= pending_cmds.pop_front();
                in_ch.valid <= 1'b1;
                drv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: compares each accepted result with the oldest prediction and
    // holds off once for a long stretch.
    int mon_gap = 0;
    int res_seen = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        t_out exp_r;
        int   gap;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                res_seen <= res_seen + 1;
                if (expected_results.size() == 0) begin
                    $error("result with nothing expected: %p", out_ch.data);
                    errors++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (out_ch.data.slot_id !== exp_r.slot_id) begin
                        $error("slot_id exp %0d got %0d", exp_r.slot_id, out_ch.data.slot_id);
                        errors++;
                    end
                    if (out_ch.data.ok !== exp_r.ok) begin
                        $error("ok exp %0d got %0d", exp_r.ok, out_ch.data.ok);
                        errors++;
                    end
                    if (out_ch.data.expired_valid !== exp_r.expired_valid) begin
                        $error("expired_valid exp %0d got %0d", exp_r.expired_valid,
                               out_ch.data.expired_valid);
                        errors++;
                    end
                    if (out_ch.data.time_to_next !== exp_r.time_to_next) begin
                        $error("time_to_next exp %0h got %0h", exp_r.time_to_next,
                               out_ch.data.time_to_next);
                        errors++;
                    end
                    if (out_ch.data.front_notify !== exp_r.front_notify) begin
                        $error("front_notify exp %0d got %0d", exp_r.front_notify,
                               out_ch.data.front_notify);
                        errors++;
                    end
                    if (out_ch.data.rollover_seen !== exp_r.rollover_seen) begin
                        $error("rollover_seen exp %0d got %0d", exp_r.rollover_seen,
                               out_ch.data.rollover_seen);
                        errors++;
                    end
                    if (out_ch.data.last !== exp_r.last) begin
                        $error("last exp %0d got %0d", exp_r.last, out_ch.data.last);
                        errors++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                out_ch.ready <= 1'b0;
            end else if (res_seen == HOLD_AT && !hold_done) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_LEN;
                out_ch.ready <= 1'b0;
            end else if (mon_gap > 0) begin
                mon_gap <= mon_gap - 1;
                out_ch.ready <= 1'b0;
            end else if (out_ch.valid && out_ch.ready) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
                mon_gap <= gap;
                out_ch.ready <= (gap == 0);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any accepted item.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("[ordered_timer_table] ERROR");
            $finish;
        end
    end

    // Every queued item has been accepted and the driver is idle.
    function automatic bit all_sent();
        return pending_cmds.size() == 0 && !in_ch.valid && drv_gap == 0;
    endfunction

    task automatic queue_cmd(t_in c);
        pending_cmds.insert(pending_cmds.size(), c);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (!all_sent() || expected_results.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        foreach (tm_valid[i]) begin
            tm_valid[i] = 0;
            tm_recur[i] = 0;
            tm_period[i] = 0;
            tm_expiry[i] = 0;
            tm_written[i] = 0;
        end
        tm_prev = 0;
        tm_tickled = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: empty table, extremes, fill to full, rollover, unknown codes.
        queue_cmd(make_cmd(CMD_EXPIRE, 4'd0, 32'd0, 1'b0, 1'b0, 64'd500));
        queue_cmd(make_cmd(CMD_NEXT, 4'd0, 32'd0, 1'b0, 1'b0, 64'd500));
        queue_cmd(make_cmd(CMD_CANCEL, 4'd15, 32'd0, 1'b0, 1'b0, 64'd500));
        queue_cmd(make_cmd(CMD_ADD, 4'd0, 32'hFFFF_0064, 1'b1, 1'b0, 64'd1000));
        queue_cmd(make_cmd(CMD_ADD, 4'd0, 32'h0000_FFFF, 1'b0, 1'b0, '1));
        for (int i = 0; i < 15; i++)
            queue_cmd(make_cmd(CMD_ADD, 4'(i), 32'(i * 7), i[0], 1'b0, 64'd1000));
        queue_cmd(make_cmd(CMD_RESET, 4'd3, 32'hFFFF_FFFF, 1'b0, 1'b0, 64'd1010));
        queue_cmd(make_cmd(CMD_RESET, 4'd4, 32'd28, 1'b0, 1'b0, 64'd1010));
        queue_cmd(make_cmd(CMD_EXPIRE, 4'd0, 32'd0, 1'b0, 1'b0, 64'd1050));
        queue_cmd(make_cmd(CMD_EXPIRE, 4'd0, 32'd0, 1'b0, 1'b0, 64'd9000000));
        queue_cmd(make_cmd(CMD_EXPIRE, 4'd0, 32'd0, 1'b0, 1'b0, 64'd2000));
        queue_cmd(make_cmd(3'd6, 4'd0, 32'd0, 1'b0, 1'b0, 64'd2000));
        queue_cmd(make_cmd(3'd7, 4'd15, '1, 1'b1, 1'b1, '1));
        queue_cmd(make_cmd(CMD_NEXT, 4'd0, 32'd0, 1'b0, 1'b0, 64'd2000));

        // Sender pauses until every expected result has come.
        wait_drained();

        // Random part; the monitor's long hold-off backs up the input meanwhile.
        for (int n = 0; n < 350; n++) begin
            queue_cmd(random_cmd());
            if (pending_cmds.size() > 8) @(posedge i_clk iff pending_cmds.size() < 4);
        end
        wait_drained();
        repeat (200) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("[ordered_timer_table] OK");
        else
            $display("[ordered_timer_table] ERROR");
        $finish;
    end
endmodule
